>>> sv/hmf_pkg.sv
// Package for the HTTP message framer: codes, byte constants, payload types
// and the Content-Length key table. No dependencies.
package hmf_pkg;

  localparam int HMF_LINE_LIMIT  = 8192;
  localparam int HMF_LENGTH_BITS = 32;
  localparam int BODY_W          = 32;

  typedef logic [7:0] byte_t;

  // byte kinds on the result channel
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HEAD = 2'd1;
  localparam logic [1:0] KIND_BODY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_LONG   = 2'd2;

  // framer modes
  localparam logic [1:0] MODE_HEAD = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_SP    = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_VT    = 8'h0B;
  localparam byte_t CH_FF    = 8'h0C;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_0     = 8'h30;
  localparam byte_t CH_9     = 8'h39;
  localparam byte_t CH_UA    = 8'h41;
  localparam byte_t CH_UZ    = 8'h5A;

  localparam logic [3:0] KEY_LEN = 4'd15;

  typedef struct packed {
    byte_t data_byte;
    logic  stream_closed;
  } hmf_item_t;

  typedef struct packed {
    byte_t              out_byte;
    logic [1:0]         byte_kind;
    logic               line_end;
    logic               head_end;
    logic               message_done;
    logic [1:0]         status;
    logic               length_known;
    logic [BODY_W-1:0]  body_length;
  } hmf_res_t;

  // control from the framer to the length scanner
  typedef struct packed {
    logic  step;   // scan this head byte
    logic  clear;  // line closed, restart scan
    byte_t data;
  } scan_ctl_t;

  // lower-case "content-length:"
  function automatic byte_t key_char(logic [3:0] idx);
    byte_t c;
    unique case (idx)
      4'd0:  c = 8'h63; // c
      4'd1:  c = 8'h6F; // o
      4'd2:  c = 8'h6E; // n
      4'd3:  c = 8'h74; // t
      4'd4:  c = 8'h65; // e
      4'd5:  c = 8'h6E; // n
      4'd6:  c = 8'h74; // t
      4'd7:  c = 8'h2D; // -
      4'd8:  c = 8'h6C; // l
      4'd9:  c = 8'h65; // e
      4'd10: c = 8'h6E; // n
      4'd11: c = 8'h67; // g
      4'd12: c = 8'h74; // t
      4'd13: c = 8'h68; // h
      4'd14: c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> sv/hmf_in_if.sv
// Input stream channel of the HTTP message framer: valid/ready plus one byte and a stream-closed flag.
// Depends on hmf_pkg.
interface hmf_in_if import hmf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  stream_closed;

  modport source (output valid, data_byte, stream_closed, input ready);
  modport sink   (input valid, data_byte, stream_closed, output ready);
endinterface

>>> sv/hmf_out_if.sv
// Result channel of the HTTP message framer: valid/ready plus result fields.
// Depends on hmf_pkg.
interface hmf_out_if import hmf_pkg::*; ();
  logic              valid;
  logic              ready;
  byte_t             out_byte;
  logic [1:0]        byte_kind;
  logic              line_end;
  logic              head_end;
  logic              message_done;
  logic [1:0]        status;
  logic              length_known;
  logic [BODY_W-1:0] body_length;

  modport source (output valid, out_byte, byte_kind, line_end, head_end, message_done,
                  status, length_known, body_length, input ready);
  modport sink   (input valid, out_byte, byte_kind, line_end, head_end, message_done,
                  status, length_known, body_length, output ready);
endinterface

>>> sv/hmf_in_reg.sv
// Input register slice of the framer: captures one transfer, releases it
// when the core takes it. Depends on hmf_pkg.
module hmf_in_reg import hmf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hmf_item_t in_item,
  input  logic      take,
  output logic      vld,
  output hmf_item_t item
);

  logic      vld_r, vld_nxt;
  hmf_item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

>>> sv/hmf_len_scan.sv
// Content-Length header scanner: prefix match, sign and decimal digits,
// one byte per step. Depends on hmf_pkg.
module hmf_len_scan import hmf_pkg::*; #(
  parameter int LENGTH_BITS = HMF_LENGTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  scan_ctl_t              ctl,
  output logic                   found,
  output logic [LENGTH_BITS-1:0] value
);

  localparam int PW = LENGTH_BITS + 4;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_SIGN   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_STOP   = 3'd5;

  logic [2:0]             phase_r, phase_nxt, phase_eff;
  logic [3:0]             idx_r, idx_nxt;
  logic [LENGTH_BITS-1:0] dv_r, dv_nxt, dv_add;
  logic                   neg_r, neg_nxt;
  logic                   ovf_r, ovf_nxt, ovf_add;
  logic [PW-1:0]          prod;
  logic                   over;
  byte_t                  b, lc;
  logic                   tabsp, space, dig;

  assign b     = ctl.data;
  assign tabsp = (b == CH_SP) || (b == CH_TAB);
  assign space = tabsp || (b == CH_CR) || (b == CH_LF) || (b == CH_VT) || (b == CH_FF);
  assign dig   = (b >= CH_0) && (b <= CH_9);
  assign lc    = ((b >= CH_UA) && (b <= CH_UZ)) ? (b + 8'd32) : b;

  // value*10 + digit; anything above the low LENGTH_BITS bits is overflow
  assign prod    = (PW'(dv_r) << 3) + (PW'(dv_r) << 1) + PW'(b[3:0]);
  assign over    = (prod[PW-1:LENGTH_BITS] != 4'd0);
  assign ovf_add = ovf_r || over;
  assign dv_add  = (ovf_r || over) ? dv_r : prod[LENGTH_BITS-1:0];

  // a non-blank byte in the lead phase is scanned as a prefix byte
  assign phase_eff = ((phase_r == PH_LEAD) && !tabsp) ? PH_PREFIX : phase_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    dv_nxt    = dv_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    found     = 1'b0;
    if (ctl.step) begin
      unique case (phase_eff)
        PH_LEAD: begin
        end
        PH_PREFIX: begin
          phase_nxt = PH_PREFIX;
          if ((idx_r < KEY_LEN) && (lc == key_char(idx_r))) begin
            idx_nxt = idx_r + 4'd1;
            if (idx_r == KEY_LEN - 4'd1) begin
              phase_nxt = PH_GAP;
            end
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_GAP: begin
          if (space) begin
          end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
            neg_nxt   = (b == CH_MINUS);
            phase_nxt = PH_SIGN;
          end else if (dig) begin
            phase_nxt = PH_DIGITS;
            dv_nxt    = dv_add;
            ovf_nxt   = ovf_add;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_SIGN: begin
          if (dig) begin
            phase_nxt = PH_DIGITS;
            dv_nxt    = dv_add;
            ovf_nxt   = ovf_add;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (dig) begin
            dv_nxt  = dv_add;
            ovf_nxt = ovf_add;
          end else begin
            // "-0" still counts as a length
            found     = !ovf_r && !(neg_r && (dv_r != '0));
            phase_nxt = PH_STOP;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl.clear) begin
      phase_nxt = PH_LEAD;
      idx_nxt   = 4'd0;
      dv_nxt    = '0;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      idx_r   <= 4'd0;
      dv_r    <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      dv_r    <= dv_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign value = dv_r;

endmodule

>>> sv/http_message_framer.sv
// Top level of the HTTP/1.1 Content-Length message framer: input slice,
// head/body state, length scanner, result register. Depends on hmf_pkg,
// hmf_in_if, hmf_out_if, hmf_in_reg and hmf_len_scan.
//
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   data_byte[7:0], stream_closed
//  out_chan  out  valid/ready   out_byte, byte_kind, line_end, head_end,
//                               message_done, status, length_known, body_length
//
// One byte per cycle sustained while out_chan is ready. The result of an input
// transfer passes through the input register, then the result register, before
// it is valid on out_chan.
// The framer state and the scanner update in the cycle a byte leaves the input
// register; the result register takes its fields at the same edge.
// A stall on out_chan holds the result register and backs up into the input
// register; in_chan.ready drops only when both are full.
// Synchronous active-low reset returns to head mode with no length known.
module http_message_framer import hmf_pkg::*; #(
  parameter int LINE_LIMIT  = HMF_LINE_LIMIT,
  parameter int LENGTH_BITS = HMF_LENGTH_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  hmf_in_if.sink    in_chan,
  hmf_out_if.source out_chan
);

  localparam int LLW = $clog2(LINE_LIMIT + 1);

  hmf_item_t in_item, s1_item;
  logic      s1_vld, take, adv;

  logic [1:0]             mode_r, mode_nxt;
  logic                   saw_cr_r, saw_cr_nxt;
  logic [LLW-1:0]         line_len_r, line_len_nxt, ln_inc;
  logic                   len_vld_r, len_vld_nxt;
  logic [LENGTH_BITS-1:0] known_r, known_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt, rem_dec;
  logic [1:0]             err_r, err_nxt;

  scan_ctl_t              sctl;
  logic                   found;
  logic [LENGTH_BITS-1:0] found_val;
  logic                   head_ok;

  hmf_res_t res_r, res_nxt;
  logic     out_vld_r, out_vld_nxt;

  logic [1:0] kind;
  logic       lend, hend, is_lf_end;
  byte_t      b;

  assign in_item.data_byte     = in_chan.data_byte;
  assign in_item.stream_closed = in_chan.stream_closed;

  hmf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_item  (in_item),
    .take     (take),
    .vld      (s1_vld),
    .item     (s1_item)
  );

  hmf_len_scan #(.LENGTH_BITS(LENGTH_BITS)) u_len_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sctl),
    .found (found),
    .value (found_val)
  );

  assign adv  = !out_vld_r || out_chan.ready;
  assign take = s1_vld && adv;

  assign b         = s1_item.data_byte;
  assign is_lf_end = saw_cr_r && (b == CH_LF);
  assign ln_inc    = line_len_r + LLW'(1);
  assign rem_dec   = (rem_r != '0) ? (rem_r - LENGTH_BITS'(1)) : rem_r;

  // head byte that is passed on (not a close, not dropped at the line limit)
  assign head_ok = take && (mode_r == MODE_HEAD) && !s1_item.stream_closed &&
                   (is_lf_end || (ln_inc != LLW'(LINE_LIMIT)));
  assign sctl    = '{step: head_ok && !len_vld_r, clear: head_ok && is_lf_end, data: b};

  always_comb begin
    mode_nxt     = mode_r;
    saw_cr_nxt   = saw_cr_r;
    line_len_nxt = line_len_r;
    rem_nxt      = rem_r;
    err_nxt      = err_r;
    kind         = KIND_NONE;
    lend         = 1'b0;
    hend         = 1'b0;
    if (take) begin
      unique case (mode_r)
        MODE_HEAD: begin
          if (s1_item.stream_closed) begin
            mode_nxt = MODE_DONE;
            err_nxt  = ST_CLOSED;
          end else if (!is_lf_end && (ln_inc == LLW'(LINE_LIMIT))) begin
            // line hits the buffer limit: byte dropped
            mode_nxt = MODE_DONE;
            err_nxt  = ST_LONG;
          end else begin
            kind         = KIND_HEAD;
            line_len_nxt = ln_inc;
            saw_cr_nxt   = (b == CH_CR);
            if (is_lf_end) begin
              lend         = 1'b1;
              line_len_nxt = '0;
              saw_cr_nxt   = 1'b0;
              if (ln_inc == LLW'(2)) begin
                hend = 1'b1;
                if (len_vld_nxt) begin
                  rem_nxt  = known_nxt;
                  mode_nxt = (known_nxt == '0) ? MODE_DONE : MODE_BODY;
                end else begin
                  mode_nxt = MODE_BODY;
                end
              end
            end
          end
        end
        MODE_BODY: begin
          if (s1_item.stream_closed) begin
            mode_nxt = MODE_DONE;
          end else begin
            kind = KIND_BODY;
            if (len_vld_r) begin
              rem_nxt = rem_dec;
              if (rem_dec == '0) begin
                mode_nxt = MODE_DONE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // found is only raised for a scanned head byte
  assign len_vld_nxt = len_vld_r || found;
  assign known_nxt   = found ? found_val : known_r;

  always_comb begin
    res_nxt.out_byte     = (kind != KIND_NONE) ? b : 8'd0;
    res_nxt.byte_kind    = kind;
    res_nxt.line_end     = lend;
    res_nxt.head_end     = hend;
    res_nxt.message_done = (mode_nxt == MODE_DONE);
    res_nxt.status       = err_nxt;
    res_nxt.length_known = len_vld_nxt;
    res_nxt.body_length  = BODY_W'(known_nxt);
  end

  assign out_vld_nxt = take ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_HEAD;
      saw_cr_r   <= 1'b0;
      line_len_r <= '0;
      len_vld_r  <= 1'b0;
      known_r    <= '0;
      rem_r      <= '0;
      err_r      <= ST_OK;
      out_vld_r  <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      saw_cr_r   <= saw_cr_nxt;
      line_len_r <= line_len_nxt;
      len_vld_r  <= len_vld_nxt;
      known_r    <= known_nxt;
      rem_r      <= rem_nxt;
      err_r      <= err_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.out_byte     = res_r.out_byte;
  assign out_chan.byte_kind    = res_r.byte_kind;
  assign out_chan.line_end     = res_r.line_end;
  assign out_chan.head_end     = res_r.head_end;
  assign out_chan.message_done = res_r.message_done;
  assign out_chan.status       = res_r.status;
  assign out_chan.length_known = res_r.length_known;
  assign out_chan.body_length  = res_r.body_length;

  // done is terminal
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DONE) |=> (mode_r == MODE_DONE))
    else $error("framer left done mode");

  // any error code means the framer has stopped
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |-> (mode_r == MODE_DONE))
    else $error("error code set outside done mode");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r < LLW'(LINE_LIMIT))
    else $error("head line length reached the limit");

  a_head_end_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.head_end) |-> (res_r.line_end && (res_r.byte_kind == KIND_HEAD)))
    else $error("head end without a closing head LF");

  // a known length, once seen, never goes away
  a_len_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    len_vld_r |=> (len_vld_r && $stable(known_r)))
    else $error("known length changed");

endmodule
